@@ hw/rtl/tap_tempo_estimator_core_defines.svh @@
// Assertion macros shared by the tap tempo RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef TAP_TEMPO_ESTIMATOR_CORE_DEFINES_SVH
`define TAP_TEMPO_ESTIMATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define TTE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tap tempo check failed");

// Next-cycle implication, disabled while in reset.
`define TTE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tap tempo check failed");

`endif

@@ hw/rtl/tte_pkg.sv @@
// Shared constants, widths and types of the tap tempo estimator.
// No dependencies; used by the channel interfaces and the core.
`timescale 1ns / 1ps

package tte_pkg;

	localparam int WINDOW_TAPS   = 8;
	localparam int SLOT_W        = (WINDOW_TAPS > 1) ? $clog2(WINDOW_TAPS) : 1;
	localparam int CNT_W         = $clog2(WINDOW_TAPS + 1);

	localparam int TIME_W        = 32;
	localparam int BPM_W         = 9;
	localparam int COUNT_W       = 4;

	localparam int BPM_MIN       = 20;
	localparam int BPM_MAX       = 300;
	localparam int BPM_RESET     = 120;
	localparam int MS_PER_MINUTE = 60000;

	// Numerator 60000*(n-1) and the span range that survives the clamp tests.
	localparam int MAX_NUM       = MS_PER_MINUTE * (WINDOW_TAPS - 1);
	localparam int NUM_W         = $clog2(MAX_NUM + 1);
	localparam int SPAN_MID_W    = $clog2(MAX_NUM / BPM_MIN + 1);
	localparam int DVS_W         = SPAN_MID_W + 1;
	localparam int DIV_W         = DVS_W + BPM_W;
	localparam int STEP_W        = $clog2(BPM_W);
	localparam int PROD_W        = TIME_W + BPM_W;

	localparam logic FUNC_TAP    = 1'b0;
	localparam logic FUNC_CLEAR  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPAN,
		ST_CLAMP,
		ST_DIV,
		ST_DONE
	} tte_state_t;

endpackage

@@ hw/rtl/tte_channels.sv @@
// Valid/ready channel interfaces for tap requests and tempo results.
// Depends on tte_pkg for field widths.
`timescale 1ns / 1ps

interface tte_tap_if;
	logic                       valid;
	logic                       ready;
	logic                       func;
	logic [tte_pkg::TIME_W-1:0] tap_time_ms;

	modport source (output valid, func, tap_time_ms, input ready);
	modport sink (input valid, func, tap_time_ms, output ready);
endinterface

interface tte_result_if;
	logic                        valid;
	logic                        ready;
	logic [tte_pkg::COUNT_W-1:0] tap_count;
	logic                        bpm_valid;
	logic [tte_pkg::BPM_W-1:0]   bpm_estimate;

	modport source (output valid, tap_count, bpm_valid, bpm_estimate, input ready);
	modport sink (input valid, tap_count, bpm_valid, bpm_estimate, output ready);
endinterface

@@ hw/rtl/tap_tempo_estimator_core.sv @@
// Tap tempo estimator: tap window memory, clamp tests and serial divider.
// Depends on tte_pkg, tte_channels.sv and tap_tempo_estimator_core_defines.svh.
//
// Usage:
//   taps    : request channel; func = tap (store tap_time_ms) or clear (empty window).
//   results : one result per request: tap_count, bpm_valid, bpm_estimate.
//   cfg_we / cfg_wdata : load a new tempo estimate directly; write only while idle.
// States passed from request acceptance to result valid:
//   clear, or a tap leaving fewer than two held : DONE
//   zero span                                    : SPAN, DONE
//   estimate clamped to 20 or 300 bpm            : SPAN, CLAMP, DONE
//   estimate by division                         : SPAN, CLAMP, DIV, DONE
// One request is in flight at a time; taps.ready returns the cycle after the result
// register is loaded. The divider, one quotient bit a cycle, sets the worst case.
// The result register decouples the sides: a new request is taken while a result still
// waits; if the receiver stalls, the next result holds in the final state until the
// register frees up.
// Reset clears the window (count and write slot) and loads 120 bpm. The tap memory
// itself is not cleared: only slots written since the last clear are ever used.
`timescale 1ns / 1ps
`include "tap_tempo_estimator_core_defines.svh"

module tap_tempo_estimator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	tte_tap_if.sink                     taps,
	tte_result_if.source                results,
	input  logic                        cfg_we,
	input  logic [tte_pkg::BPM_W-1:0]   cfg_wdata
);

	// Tap window: one 32-bit timestamp per slot, synchronous read.
	logic [tte_pkg::TIME_W-1:0]     tap_mem [tte_pkg::WINDOW_TAPS];

	tte_pkg::tte_state_t            state_q, state_d;

	logic [tte_pkg::SLOT_W-1:0]     ws_q;
	logic [tte_pkg::CNT_W-1:0]      held_q;
	logic [tte_pkg::BPM_W-1:0]      tempo_q;

	logic [tte_pkg::TIME_W-1:0]     newest_s1;
	logic [tte_pkg::TIME_W-1:0]     oldest_s2;
	logic [tte_pkg::TIME_W-1:0]     span_q;
	logic [tte_pkg::NUM_W-1:0]      num_q;
	logic [tte_pkg::DIV_W-1:0]      rem_q;
	logic [tte_pkg::DIV_W-1:0]      dvs_q;
	logic [tte_pkg::BPM_W-1:0]      quo_q;
	logic [tte_pkg::STEP_W-1:0]     step_q;

	logic                           res_valid_q;
	logic [tte_pkg::COUNT_W-1:0]    res_count_q;
	logic                           res_bpm_valid_q;
	logic [tte_pkg::BPM_W-1:0]      res_bpm_q;

	logic                           tap_acc;
	logic                           res_free;
	logic [tte_pkg::CNT_W-1:0]      held_inc;
	logic [tte_pkg::SLOT_W-1:0]     ws_inc;
	logic [tte_pkg::SLOT_W-1:0]     rd_addr;
	logic [tte_pkg::TIME_W-1:0]     span_now;
	logic [tte_pkg::NUM_W-1:0]      num_now;
	logic [tte_pkg::PROD_W-1:0]     num_wide;
	logic [tte_pkg::PROD_W-1:0]     span_hi;
	logic [tte_pkg::PROD_W-1:0]     span_lo;
	logic                           clamp_hi;
	logic                           clamp_lo;
	logic [tte_pkg::DIV_W-1:0]      div_rem_init;
	logic [tte_pkg::DIV_W-1:0]      div_dvs_init;
	logic                           div_fits;
	logic                           ld_tap;
	logic                           ld_clear;
	logic                           ld_span;
	logic                           ld_div;
	logic                           ld_result;

	assign tap_acc  = taps.valid && taps.ready;
	assign res_free = !res_valid_q || results.ready;

	// Window bookkeeping: count saturates at the window size, slot wraps.
	assign held_inc = (held_q == tte_pkg::CNT_W'(tte_pkg::WINDOW_TAPS)) ?
			held_q : held_q + 1'b1;
	assign ws_inc   = (ws_q == tte_pkg::SLOT_W'(tte_pkg::WINDOW_TAPS - 1)) ?
			'0 : ws_q + 1'b1;

	// Until the window fills, slots fill from zero, so the oldest tap sits in slot 0.
	// Once full, the oldest is the slot that the next tap will overwrite.
	assign rd_addr  = (held_inc == tte_pkg::CNT_W'(tte_pkg::WINDOW_TAPS)) ? ws_inc : '0;

	// Span wraps modulo 2^32; numerator is 60000*(n-1) with n already updated.
	assign span_now = newest_s1 - oldest_s2;
	assign num_now  = tte_pkg::NUM_W'(32'(tte_pkg::MS_PER_MINUTE) * 32'(held_q - 1'b1));

	// Clamp tests against 300*span and 20*span.
	assign num_wide = tte_pkg::PROD_W'(num_q);
	assign span_hi  = tte_pkg::PROD_W'(span_q) * tte_pkg::PROD_W'(tte_pkg::BPM_MAX);
	assign span_lo  = tte_pkg::PROD_W'(span_q) * tte_pkg::PROD_W'(tte_pkg::BPM_MIN);
	assign clamp_hi = num_wide >= span_hi;
	assign clamp_lo = num_wide <= span_lo;

	// Past the clamp tests the span is narrow, so round-half-up division
	// (2*num + span) / (2*span) fits the divider width.
	assign div_rem_init = tte_pkg::DIV_W'({num_q, 1'b0}) +
			tte_pkg::DIV_W'(span_q[tte_pkg::SPAN_MID_W-1:0]);
	assign div_dvs_init = tte_pkg::DIV_W'({span_q[tte_pkg::SPAN_MID_W-1:0], 1'b0})
			<< (tte_pkg::BPM_W - 1);
	assign div_fits     = rem_q >= dvs_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tte_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and stage controls.
	always_comb begin
		state_d    = state_q;
		taps.ready = 1'b0;
		ld_tap     = 1'b0;
		ld_clear   = 1'b0;
		ld_span    = 1'b0;
		ld_div     = 1'b0;
		ld_result  = 1'b0;
		unique case (state_q)
			tte_pkg::ST_IDLE: begin
				taps.ready = 1'b1;
				if (tap_acc) begin
					if (taps.func == tte_pkg::FUNC_CLEAR) begin
						ld_clear = 1'b1;
						state_d  = tte_pkg::ST_DONE;
					end else begin
						ld_tap  = 1'b1;
						state_d = (held_inc < tte_pkg::CNT_W'(2)) ?
								tte_pkg::ST_DONE : tte_pkg::ST_SPAN;
					end
				end
			end
			tte_pkg::ST_SPAN: begin
				// Zero span leaves the estimate as it is.
				if (span_now == '0) begin
					state_d = tte_pkg::ST_DONE;
				end else begin
					ld_span = 1'b1;
					state_d = tte_pkg::ST_CLAMP;
				end
			end
			tte_pkg::ST_CLAMP: begin
				if (clamp_hi || clamp_lo) begin
					state_d = tte_pkg::ST_DONE;
				end else begin
					ld_div  = 1'b1;
					state_d = tte_pkg::ST_DIV;
				end
			end
			tte_pkg::ST_DIV: begin
				if (step_q == '0) begin
					state_d = tte_pkg::ST_DONE;
				end
			end
			tte_pkg::ST_DONE: begin
				// Hold here while the previous result is still waiting.
				if (res_free) begin
					ld_result = 1'b1;
					state_d   = tte_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tte_pkg::ST_IDLE;
			end
		endcase
	end

	// Tap memory: write the new tap and read the oldest one in the same cycle.
	// Slots meet only on a tap into an empty window (read unused); the next request waits.
	always_ff @(posedge clk) begin
		if (ld_tap) begin
			tap_mem[ws_q] <= taps.tap_time_ms;
			oldest_s2     <= tap_mem[rd_addr];
		end
	end

	// Window control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q   <= '0;
			held_q <= '0;
		end else if (ld_clear) begin
			ws_q   <= '0;
			held_q <= '0;
		end else if (ld_tap) begin
			ws_q   <= ws_inc;
			held_q <= held_inc;
		end
	end

	// Tempo estimate: clamp, divider result, or a direct configuration load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tempo_q <= tte_pkg::BPM_W'(tte_pkg::BPM_RESET);
		end else if (cfg_we) begin
			tempo_q <= cfg_wdata;
		end else if (state_q == tte_pkg::ST_CLAMP && clamp_hi) begin
			tempo_q <= tte_pkg::BPM_W'(tte_pkg::BPM_MAX);
		end else if (state_q == tte_pkg::ST_CLAMP && clamp_lo) begin
			tempo_q <= tte_pkg::BPM_W'(tte_pkg::BPM_MIN);
		end else if (state_q == tte_pkg::ST_DIV && step_q == '0) begin
			tempo_q <= {quo_q[tte_pkg::BPM_W-2:0], div_fits};
		end
	end

	// Span, numerator and the restoring divider: one quotient bit per cycle,
	// divisor walks right from its top alignment.
	always_ff @(posedge clk) begin
		if (ld_tap) begin
			newest_s1 <= taps.tap_time_ms;
		end
		if (ld_span) begin
			span_q <= span_now;
			num_q  <= num_now;
		end
		if (ld_div) begin
			rem_q  <= div_rem_init;
			dvs_q  <= div_dvs_init;
			quo_q  <= '0;
			step_q <= tte_pkg::STEP_W'(tte_pkg::BPM_W - 1);
		end else if (state_q == tte_pkg::ST_DIV) begin
			if (div_fits) begin
				rem_q <= rem_q - dvs_q;
			end
			dvs_q  <= dvs_q >> 1;
			quo_q  <= {quo_q[tte_pkg::BPM_W-2:0], div_fits};
			step_q <= step_q - 1'b1;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ld_result) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_result) begin
			res_count_q     <= tte_pkg::COUNT_W'(held_q);
			res_bpm_valid_q <= held_q >= tte_pkg::CNT_W'(2);
			res_bpm_q       <= tempo_q;
		end
	end

	assign results.valid        = res_valid_q;
	assign results.tap_count    = res_count_q;
	assign results.bpm_valid    = res_bpm_valid_q;
	assign results.bpm_estimate = res_bpm_q;

	`TTE_ASSERT_NOW(a_slot_tracks_count, held_q < tte_pkg::CNT_W'(tte_pkg::WINDOW_TAPS), ws_q == tte_pkg::SLOT_W'(held_q))
	`TTE_ASSERT_NEXT(a_clear_empties, tap_acc && taps.func == tte_pkg::FUNC_CLEAR, held_q == '0 && ws_q == '0)
	`TTE_ASSERT_NOW(a_div_nonzero, state_q == tte_pkg::ST_DIV, dvs_q != '0)
	`TTE_ASSERT_NEXT(a_div_in_range, state_q == tte_pkg::ST_DIV && step_q == '0, tempo_q >= tte_pkg::BPM_W'(tte_pkg::BPM_MIN) && tempo_q <= tte_pkg::BPM_W'(tte_pkg::BPM_MAX))

endmodule
